FILE: hw/rtl/dapt_pkg.sv
// Shared types, register codes and field layout of the divider and timer block.
`default_nettype none

package dapt_pkg;

    // Default width of the tick counts handled internally
    localparam int DEF_TICK_BITS = 12;

    // Stream field layout
    localparam int TICK_FIELD_W  = 12;
    localparam int IN_DATA_W     = 16;
    localparam int IN_USER_W     = 1;
    localparam int OUT_DATA_W    = 32;
    localparam int OUT_DIV_LSB   = 0;
    localparam int OUT_TIM_LSB   = 8;
    localparam int OUT_IRQ_BIT   = 16;
    localparam int OUT_ANS_LSB   = 17;
    localparam int OUT_ANS_W     = 12;
    localparam int OUT_USED_W    = OUT_ANS_LSB + OUT_ANS_W;

    // Configuration port
    localparam int APB_ADDR_W    = 4;
    localparam int APB_DATA_W    = 32;

    // Timer constants
    localparam int PRESC_W       = 9;
    localparam int CNT_W         = 8;

    typedef enum logic [1:0] {
        REG_TIMER_ENABLE = 2'd0,
        REG_CLOCK_SELECT = 2'd1,
        REG_MODULO_VALUE = 2'd2,
        REG_DOUBLE_SPEED = 2'd3
    } t_reg_idx;

    typedef enum logic {
        ACT_ADVANCE = 1'b0,
        ACT_QUERY   = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_DIV,
        ST_FIN
    } t_state;

endpackage

`default_nettype wire

FILE: hw/rtl/divider_and_programmable_timer.sv
// Top level of the divider and programmable timer block.
//
//  channel   | direction | transaction             | payload
//  ----------+-----------+-------------------------+------------------------------------
//  s_axis    | in        | tvalid & tready         | tdata: tick_count; tuser: action
//  m_axis    | out       | tvalid & tready         | tdata: divider, timer, irq, answer
//  apb       | in        | psel & penable & pwrite | one of four config registers
//
//  Sequence: a query or an advance without timer overflow steps from accept
//  through compute to hand-off. An advance that overflows the timer also
//  reduces the timer sum to the reload remainder, bit-serially on one
//  compare/subtract unit.
//  Reset: synchronous, clears configuration, counters and both handshakes; no
//  clearing pass is needed. A result waiting on a low m_axis_tready holds the
//  sequencer in its hand-off state; the input stays unready until it moves on.
`default_nettype none

module divider_and_programmable_timer
    import dapt_pkg::*;
#(
    parameter int TICK_BITS = DEF_TICK_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // input stream
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // [11:0] tick_count
    input  wire logic [IN_USER_W-1:0]  s_axis_tuser,   // [0] action
    // result stream
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,   // [7:0] divider_value,
                                                       // [15:8] timer_value,
                                                       // [16] timer_interrupt,
                                                       // [28:17] ticks_to_overflow
    // configuration port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready
);

    // Internal widths: shifted tick count, divider sum, prescaler sum, its
    // carry-out count, the timer sum and the bit counter of the remainder unit.
    localparam int TW = TICK_BITS;
    localparam int CW = TW + 1;
    localparam int AW = ((TW + 2 > CNT_W) ? TW + 2 : CNT_W) + 1;
    localparam int PW = TW + 8;
    localparam int QW = PW - PRESC_W;
    localparam int XW = ((QW > CNT_W) ? QW : CNT_W) + 1;
    localparam int KW = $clog2(XW);
    localparam int QRY_W = 18;

    t_state r_state, n_state;

    // configuration
    logic       r_enable;
    logic [1:0] r_clk_sel;
    logic [7:0] r_modulo;
    logic       r_dbl;

    // timer state
    logic [7:0]         r_div_frac, n_div_frac;
    logic [PRESC_W-1:0] r_presc,    n_presc;
    logic [7:0]         r_div_cnt,  n_div_cnt;
    logic [7:0]         r_tim_cnt,  n_tim_cnt;

    // captured item and result
    logic          r_action,  n_action;
    logic [TW-1:0] r_ticks,   n_ticks;
    logic          r_irq,     n_irq;
    logic [11:0]   r_answer,  n_answer;

    // remainder unit
    logic [XW-1:0] r_dvd,     n_dvd;
    logic [7:0]    r_rem,     n_rem;
    logic [KW-1:0] r_bit_cnt, n_bit_cnt;

    // output register
    logic                  r_out_valid, n_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data,  n_out_data;

    logic [TW-1:0] w_ticks_in;
    logic          w_in_acc;
    logic          w_cfg_wr;

    // Take the low TICK_BITS bits of the tick field, zero-extended when TICK_BITS is wider.
    if (TW <= TICK_FIELD_W) begin : g_tick_trunc
        assign w_ticks_in = s_axis_tdata[TW-1:0];
    end else begin : g_tick_ext
        assign w_ticks_in = {{(TW - TICK_FIELD_W){1'b0}}, s_axis_tdata[TICK_FIELD_W-1:0]};
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable  <= 1'b0;
            r_clk_sel <= 2'd0;
            r_modulo  <= 8'd0;
            r_dbl     <= 1'b0;
        end else if (w_cfg_wr) begin
            case (t_reg_idx'(paddr[3:2]))
                REG_TIMER_ENABLE: r_enable  <= pwdata[0];
                REG_CLOCK_SELECT: r_clk_sel <= pwdata[1:0];
                REG_MODULO_VALUE: r_modulo  <= pwdata[7:0];
                REG_DOUBLE_SPEED: r_dbl     <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (t_reg_idx'(paddr[3:2]))
            REG_TIMER_ENABLE: prdata = {{(APB_DATA_W-1){1'b0}}, r_enable};
            REG_CLOCK_SELECT: prdata = {{(APB_DATA_W-2){1'b0}}, r_clk_sel};
            REG_MODULO_VALUE: prdata = {{(APB_DATA_W-8){1'b0}}, r_modulo};
            REG_DOUBLE_SPEED: prdata = {{(APB_DATA_W-1){1'b0}}, r_dbl};
            default:          prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Step arithmetic
    // ------------------------------------------------------------------
    logic [1:0]         w_negsel;
    logic [2:0]         w_shift;
    logic [CW-1:0]      w_cnt;
    logic [AW-1:0]      w_acc;
    logic [PW-1:0]      w_p;
    logic [XW-1:0]      w_t;
    logic [8:0]         w_period;
    logic [9:0]         w_c1;
    logic [QRY_W-1:0]   w_c2;
    logic [QRY_W-1:0]   w_c;
    logic [QRY_W-1:0]   w_cap;
    logic [QRY_W-1:0]   w_min;
    logic [11:0]        w_query;
    logic [8:0]         w_shin;
    logic [8:0]         w_rem_next;

    // Prescale shift is ((-sel) mod 4) * 2.
    assign w_negsel = 2'd0 - r_clk_sel;
    assign w_shift  = {w_negsel, 1'b0};

    assign w_cnt    = CW'(r_ticks) << r_dbl;
    assign w_acc    = AW'(r_div_frac) + (AW'(w_cnt) << 1);
    assign w_p      = PW'(r_presc) + (PW'(w_cnt) << w_shift);
    assign w_t      = XW'(r_tim_cnt) + XW'(w_p[PW-1:PRESC_W]);
    assign w_period = 9'd256 - {1'b0, r_modulo};

    // Ticks until the prescaler carries, then full prescaler laps until the timer overflows.
    assign w_c1  = (10'd511 - {1'b0, r_presc} + (10'd1 << w_shift)) >> w_shift;
    assign w_c2  = QRY_W'(8'd255 - r_tim_cnt) << (4'd9 - {1'b0, w_shift});
    assign w_c   = QRY_W'(w_c1) + w_c2;
    assign w_cap = QRY_W'(r_ticks);
    assign w_min = (r_enable && (w_c < w_cap)) ? w_c : w_cap;
    assign w_query = (w_min > QRY_W'(12'hfff)) ? 12'hfff : w_min[11:0];

    // One restoring step of the reload remainder.
    assign w_shin     = {r_rem, r_dvd[XW-1]};
    assign w_rem_next = (w_shin >= w_period) ? (w_shin - w_period) : w_shin;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_div_frac  = r_div_frac;
        n_presc     = r_presc;
        n_div_cnt   = r_div_cnt;
        n_tim_cnt   = r_tim_cnt;
        n_action    = r_action;
        n_ticks     = r_ticks;
        n_irq       = r_irq;
        n_answer    = r_answer;
        n_dvd       = r_dvd;
        n_rem       = r_rem;
        n_bit_cnt   = r_bit_cnt;
        n_out_data  = r_out_data;
        // drop valid once the result is taken
        n_out_valid = r_out_valid && !m_axis_tready;

        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_action = s_axis_tuser[0];
                    n_ticks  = w_ticks_in;
                    n_state  = ST_CALC;
                end
            end
            ST_CALC: begin
                n_irq   = 1'b0;
                n_state = ST_FIN;
                if (t_action'(r_action) == ACT_QUERY) begin
                    n_answer = w_query;
                end else begin
                    n_answer   = 12'd0;
                    n_div_cnt  = r_div_cnt + 8'(w_acc[AW-1:8]);
                    n_div_frac = w_acc[7:0];
                    if (r_enable) begin
                        n_presc = w_p[PRESC_W-1:0];
                        if (w_t >= XW'(256)) begin
                            // overflow: reduce (t - modulo) mod period serially
                            n_irq     = 1'b1;
                            n_dvd     = w_t - XW'(r_modulo);
                            n_rem     = 8'd0;
                            n_bit_cnt = KW'(XW - 1);
                            n_state   = ST_DIV;
                        end else begin
                            n_tim_cnt = w_t[7:0];
                        end
                    end
                end
            end
            ST_DIV: begin
                n_rem = w_rem_next[7:0];
                n_dvd = r_dvd << 1;
                if (r_bit_cnt == '0) begin
                    n_tim_cnt = r_modulo + w_rem_next[7:0];
                    n_state   = ST_FIN;
                end else begin
                    n_bit_cnt = r_bit_cnt - KW'(1);
                end
            end
            ST_FIN: begin
                // hand the result over once the output register is free
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {{(OUT_DATA_W-OUT_USED_W){1'b0}},
                                   r_answer, r_irq, r_tim_cnt, r_div_cnt};
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_frac  <= 8'd0;
            r_presc     <= '0;
            r_div_cnt   <= 8'd0;
            r_tim_cnt   <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_div_frac  <= n_div_frac;
            r_presc     <= n_presc;
            r_div_cnt   <= n_div_cnt;
            r_tim_cnt   <= n_tim_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action   <= n_action;
        r_ticks    <= n_ticks;
        r_irq      <= n_irq;
        r_answer   <= n_answer;
        r_dvd      <= n_dvd;
        r_rem      <= n_rem;
        r_bit_cnt  <= n_bit_cnt;
        r_out_data <= n_out_data;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/dapt_checker.sv
// Port-level assertions for the divider and timer block, bound to its top level.
`default_nettype none

module dapt_checker
    import dapt_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  s_axis_tvalid,
    input wire logic                  s_axis_tready,
    input wire logic                  m_axis_tvalid,
    input wire logic                  m_axis_tready,
    input wire logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // One item at a time: input goes unready right after a transaction.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while busy");

    // Reset leaves no result pending.
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // A query never raises the interrupt; an overflowing advance answers zero.
    a_irq_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[OUT_IRQ_BIT]
        |-> m_axis_tdata[OUT_ANS_LSB +: OUT_ANS_W] == '0)
        else $error("interrupt with nonzero answer");

endmodule

bind divider_and_programmable_timer dapt_checker u_dapt_checker (.*);

`default_nettype wire

FILE: sim/tb_top.sv
// Self-checking testbench for the divider and programmable timer block.
`timescale 1ns / 1ps

module tb_top;
    import dapt_pkg::*;

    localparam int CLK_HALF         = 5;
    localparam int RESET_CYCLES     = 11;
    // Worst case accept-to-result is an overflow with serial reload
    localparam int SETTLE_CYCLES    = 20;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int PHASES           = 28;
    localparam int PHASE_ITEMS      = 50;
    localparam int TICK_MAX         = 4095;

    // One result transaction, unpacked from m_axis_tdata
    typedef struct packed {
        logic [CNT_W-1:0]        div;
        logic [CNT_W-1:0]        tim;
        logic                    irq;
        logic [OUT_ANS_W-1:0]    ans;
    } t_reading;

    typedef enum logic { ROW_CFG, ROW_ITEM } t_row_kind;

    // One line of the directed table: a register write or a stream transaction.
    // typed rows carry a hand-written expectation; the rest use the predictor.
    typedef struct packed {
        t_row_kind               kind;
        t_reg_idx                idx;
        logic [7:0]              value;
        t_action                 act;
        logic [TICK_FIELD_W-1:0] ticks;
        logic                    typed;
        t_reading                want;
    } t_stim_row;

    localparam int N_ROWS = 29;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [IN_DATA_W-1:0]    s_axis_tdata;   // [11:0] tick_count
    logic [IN_USER_W-1:0]    s_axis_tuser;   // [0] action
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [OUT_DATA_W-1:0]   m_axis_tdata;   // [7:0] divider_value, [15:8] timer_value,
                                             // [16] timer_interrupt, [28:17] ticks_to_overflow
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [APB_ADDR_W-1:0]   paddr;
    logic [APB_DATA_W-1:0]   pwdata;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;

    // Shadow configuration, updated when a register write completes
    logic                    cfg_enable;
    logic [1:0]              cfg_sel;
    logic [7:0]              cfg_mod;
    logic                    cfg_ds;

    // Shadow timebase state
    logic [7:0]              frac_acc;
    logic [PRESC_W-1:0]      presc_count;
    logic [CNT_W-1:0]        div_count;
    logic [CNT_W-1:0]        tim_count;

    t_reading                pending_readings[$];
    int                      fail_count = 0;
    int                      send_quiet = 0;
    bit                      hold_results = 1'b0;

    // Directed table: reset values and cap passthrough first, then every clock
    // select, both reload extremes, double speed, and finally a disabled timer.
    t_stim_row directed_rows [N_ROWS] = '{
        '{ROW_ITEM, REG_TIMER_ENABLE, 8'd0,   ACT_QUERY,   12'd4095, 1'b1,
          '{8'd0,  8'd0, 1'b0, 12'd4095}},
        '{ROW_ITEM, REG_TIMER_ENABLE, 8'd0,   ACT_QUERY,   12'd0,    1'b1,
          '{8'd0,  8'd0, 1'b0, 12'd0}},
        '{ROW_ITEM, REG_TIMER_ENABLE, 8'd0,   ACT_ADVANCE, 12'd0,    1'b1,
          '{8'd0,  8'd0, 1'b0, 12'd0}},
        // timer off: only the divider moves, 2*4095 = 31*256 + 254
        '{ROW_ITEM, REG_TIMER_ENABLE, 8'd0,   ACT_ADVANCE, 12'd4095, 1'b1,
          '{8'd31, 8'd0, 1'b0, 12'd0}},
        '{ROW_CFG,  REG_TIMER_ENABLE, 8'd1,   ACT_ADVANCE, 12'd0,    1'b0, '0},
        '{ROW_ITEM, REG_TIMER_ENABLE, 8'd0,   ACT_QUERY,   12'd4095, 1'b0, '0},
        '{ROW_ITEM, REG_TIMER_ENABLE, 8'd0,   ACT_QUERY,   12'd1,    1'b0, '0},
        '{ROW_ITEM, REG_TIMER_ENABLE, 8'd0,   ACT_ADVANCE, 12'd4095, 1'b0, '0},
        '{ROW_ITEM, REG_TIMER_ENABLE, 8'd0,   ACT_ADVANCE, 12'd1,    1'b0, '0},
        '{ROW_CFG,  REG_CLOCK_SELECT, 8'd1,   ACT_ADVANCE, 12'd0,    1'b0, '0},
        '{ROW_ITEM, REG_TIMER_ENABLE, 8'd0,   ACT_QUERY,   12'd4095, 1'b0, '0},
        '{ROW_ITEM, REG_TIMER_ENABLE, 8'd0,   ACT_ADVANCE, 12'd4095, 1'b0, '0},
        '{ROW_CFG,  REG_MODULO_VALUE, 8'd255, ACT_ADVANCE, 12'd0,    1'b0, '0},
        '{ROW_ITEM, REG_TIMER_ENABLE, 8'd0,   ACT_ADVANCE, 12'd4095, 1'b0, '0},
        '{ROW_ITEM, REG_TIMER_ENABLE, 8'd0,   ACT_QUERY,   12'd0,    1'b0, '0},
        '{ROW_CFG,  REG_MODULO_VALUE, 8'd128, ACT_ADVANCE, 12'd0,    1'b0, '0},
        '{ROW_CFG,  REG_DOUBLE_SPEED, 8'd1,   ACT_ADVANCE, 12'd0,    1'b0, '0},
        '{ROW_ITEM, REG_TIMER_ENABLE, 8'd0,   ACT_ADVANCE, 12'd4095, 1'b0, '0},
        '{ROW_ITEM, REG_TIMER_ENABLE, 8'd0,   ACT_ADVANCE, 12'd2048, 1'b0, '0},
        '{ROW_ITEM, REG_TIMER_ENABLE, 8'd0,   ACT_QUERY,   12'd4095, 1'b0, '0},
        '{ROW_CFG,  REG_CLOCK_SELECT, 8'd2,   ACT_ADVANCE, 12'd0,    1'b0, '0},
        '{ROW_ITEM, REG_TIMER_ENABLE, 8'd0,   ACT_ADVANCE, 12'd3000, 1'b0, '0},
        '{ROW_ITEM, REG_TIMER_ENABLE, 8'd0,   ACT_QUERY,   12'd4095, 1'b0, '0},
        '{ROW_CFG,  REG_CLOCK_SELECT, 8'd3,   ACT_ADVANCE, 12'd0,    1'b0, '0},
        '{ROW_ITEM, REG_TIMER_ENABLE, 8'd0,   ACT_ADVANCE, 12'd4095, 1'b0, '0},
        '{ROW_ITEM, REG_TIMER_ENABLE, 8'd0,   ACT_QUERY,   12'd2,    1'b0, '0},
        '{ROW_CFG,  REG_TIMER_ENABLE, 8'd0,   ACT_ADVANCE, 12'd0,    1'b0, '0},
        '{ROW_ITEM, REG_TIMER_ENABLE, 8'd0,   ACT_QUERY,   12'd1234, 1'b0, '0},
        '{ROW_ITEM, REG_TIMER_ENABLE, 8'd0,   ACT_ADVANCE, 12'd4095, 1'b0, '0}
    };

    divider_and_programmable_timer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Advance the shadow timebase by one accepted transaction and return
    // the reading the block must report for it.
    function automatic t_reading predict_timer_step(t_action act,
                                                    logic [TICK_FIELD_W-1:0] ticks);
        t_reading r;
        int cnt, acc, sh, p, t, c, ans;
        r   = '0;
        ans = 0;
        sh  = ((4 - int'(cfg_sel)) & 3) << 1;
        if (act == ACT_ADVANCE) begin
            // scale by speed mode, then feed the divider at twice the rate
            cnt       = int'(ticks) << cfg_ds;
            acc       = int'(frac_acc) + (cnt << 1);
            div_count = CNT_W'(int'(div_count) + (acc >> 8));
            frac_acc  = 8'(acc);
            if (cfg_enable) begin
                p           = int'(presc_count) + (cnt << sh);
                t           = int'(tim_count) + (p >> PRESC_W);
                presc_count = PRESC_W'(p);
                if (t >= 256) begin
                    // fold repeated reloads into one remainder
                    r.irq = 1'b1;
                    t     = int'(cfg_mod) + ((t - int'(cfg_mod)) % (256 - int'(cfg_mod)));
                end
                tim_count = CNT_W'(t);
            end
        end else if (cfg_enable) begin
            // query ignores speed mode; answer capped at the tick count
            c   = (511 - int'(presc_count) + (1 << sh)) >> sh;
            c  += (255 - int'(tim_count)) << (9 - sh);
            ans = (c < int'(ticks)) ? c : int'(ticks);
        end else begin
            ans = int'(ticks);
        end
        if (ans > TICK_MAX)
            ans = TICK_MAX;
        r.div = div_count;
        r.tim = tim_count;
        r.ans = OUT_ANS_W'(ans);
        return r;
    endfunction

    function automatic logic [TICK_FIELD_W-1:0] pick_ticks();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return TICK_FIELD_W'(TICK_MAX);
            2:       return TICK_FIELD_W'($urandom_range(0, 15));
            default: return TICK_FIELD_W'($urandom_range(0, TICK_MAX));
        endcase
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Offer one transaction after a random gap, hold it until accepted and
    // record its expectation. tvalid stays high on return; the next call or
    // wait_drained decides whether it drops.
    task automatic push_item(input t_action act, input logic [TICK_FIELD_W-1:0] ticks,
                             input logic typed, input t_reading want,
                             output t_reading predicted);
        int gap;
        if (send_quiet == 0 && $urandom_range(0, 29) == 0)
            send_quiet = 25;
        gap = (send_quiet > 0) ? 0 : $urandom_range(0, 12);
        if (send_quiet > 0)
            send_quiet--;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_DATA_W'(ticks);
        s_axis_tuser  <= IN_USER_W'(act);
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = predict_timer_step(act, ticks);
        pending_readings.push_back(typed ? want : predicted);
    endtask

    // Drop tvalid and hold until every outstanding result has been taken.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_readings.size() != 0);
    endtask

    // Write one register (setup + access), mirror it, then read it back.
    task automatic write_reg(input t_reg_idx idx, input logic [7:0] val);
        logic [APB_DATA_W-1:0] masked, readback;
        case (idx)
            REG_TIMER_ENABLE: masked = APB_DATA_W'(val[0]);
            REG_CLOCK_SELECT: masked = APB_DATA_W'(val[1:0]);
            REG_MODULO_VALUE: masked = APB_DATA_W'(val);
            default:          masked = APB_DATA_W'(val[0]);
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'({idx, 2'b00});
        pwdata  <= masked;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_TIMER_ENABLE: cfg_enable = masked[0];
            REG_CLOCK_SELECT: cfg_sel    = masked[1:0];
            REG_MODULO_VALUE: cfg_mod    = masked[7:0];
            default:          cfg_ds     = masked[0];
        endcase
        // read back the same address
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(negedge i_clk);
            readback = prdata;
            @(posedge i_clk);
        end while (!pready);
        // leave the bus idle before the next access
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        if (readback !== masked) begin
            $error("%s readback: expected %0d, got %0d", idx.name(), masked, readback);
            fail_count++;
        end
    endtask

    // Result side: random backpressure, quiet stretches, and one long hold-off
    // on request so the block fills and stalls its input.
    initial begin
        int gap;
        int quiet;
        quiet = 0;
        m_axis_tready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_results) begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
                hold_results = 1'b0;
            end
            if (quiet == 0 && $urandom_range(0, 29) == 0)
                quiet = 25;
            gap = (quiet > 0) ? 0 : $urandom_range(0, 12);
            if (quiet > 0)
                quiet--;
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(i_rst_n && m_axis_tvalid));
        end
    end

    // Compare every taken result against the oldest expectation.
    always @(posedge i_clk) begin : result_check
        t_reading want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_readings.size() == 0) begin
                $error("result with nothing pending: tdata=0x%08h", m_axis_tdata);
                fail_count++;
            end else begin
                want = pending_readings.pop_front();
                check_field("divider_value", want.div,
                            m_axis_tdata[OUT_DIV_LSB +: CNT_W]);
                check_field("timer_value", want.tim,
                            m_axis_tdata[OUT_TIM_LSB +: CNT_W]);
                check_field("timer_interrupt", want.irq,
                            m_axis_tdata[OUT_IRQ_BIT]);
                check_field("ticks_to_overflow", want.ans,
                            m_axis_tdata[OUT_ANS_LSB +: OUT_ANS_W]);
            end
        end
    end

    // Stimulus: reset, directed table, then randomized configuration phases.
    initial begin
        int row, phase, n, next_ticks;
        t_reading seen;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        i_rst_n       <= 1'b0;
        cfg_enable  = 1'b0;
        cfg_sel     = '0;
        cfg_mod     = '0;
        cfg_ds      = 1'b0;
        frac_acc    = '0;
        presc_count = '0;
        div_count   = '0;
        tim_count   = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table; drain before every register write.
        for (row = 0; row < N_ROWS; row++) begin
            if (directed_rows[row].kind == ROW_CFG) begin
                wait_drained();
                write_reg(directed_rows[row].idx, directed_rows[row].value);
            end else begin
                push_item(directed_rows[row].act, directed_rows[row].ticks,
                          directed_rows[row].typed, directed_rows[row].want, seen);
            end
        end

        for (phase = 0; phase < PHASES; phase++) begin
            wait_drained();
            // Reprogram every register; keep the timer mostly on so the
            // prescaler and reload paths see most of the traffic.
            write_reg(REG_TIMER_ENABLE, (phase == 1) ? 8'd0 : 8'($urandom_range(0, 3) != 0));
            write_reg(REG_CLOCK_SELECT, 8'($urandom_range(0, 3)));
            case ($urandom_range(0, 3))
                0:       write_reg(REG_MODULO_VALUE, 8'd0);
                1:       write_reg(REG_MODULO_VALUE, 8'd255);
                2:       write_reg(REG_MODULO_VALUE, 8'($urandom_range(0, 255)));
                default: write_reg(REG_MODULO_VALUE, 8'($urandom_range(192, 254)));
            endcase
            write_reg(REG_DOUBLE_SPEED, 8'($urandom_range(0, 1)));

            // First phase: stall the result side for a long stretch while
            // the input keeps streaming back to back.
            if (phase == 0) begin
                hold_results = 1'b1;
                send_quiet   = 40;
            end

            n = 0;
            while (n < PHASE_ITEMS) begin
                case ($urandom_range(0, 5))
                    0, 1: push_item(ACT_ADVANCE, pick_ticks(), 1'b0, '0, seen);
                    2:    push_item(ACT_QUERY, pick_ticks(), 1'b0, '0, seen);
                    3: begin
                        // Ask for the distance to overflow, then step right
                        // around it to land on the reload boundary.
                        push_item(ACT_QUERY, TICK_FIELD_W'(TICK_MAX), 1'b0, '0, seen);
                        next_ticks = int'(seen.ans) + int'($urandom_range(0, 2)) - 1;
                        if (next_ticks < 0)
                            next_ticks = 0;
                        if (next_ticks > TICK_MAX)
                            next_ticks = TICK_MAX;
                        push_item(ACT_ADVANCE, TICK_FIELD_W'(next_ticks), 1'b0, '0, seen);
                        n++;
                    end
                    4:    push_item(ACT_ADVANCE, TICK_FIELD_W'($urandom_range(0, 15)),
                                    1'b0, '0, seen);
                    default: push_item(ACT_QUERY, TICK_FIELD_W'($urandom_range(0, 15)),
                                       1'b0, '0, seen);
                endcase
                n++;
                // Pause the input once mid-phase until everything is back.
                if (phase == PHASES / 2 && n == PHASE_ITEMS / 2)
                    wait_drained();
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Hard stop on a hung handshake.
    initial begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
